// ===== rtl/core/zbuffer_point_splat_shader_assert.svh =====
// assertion macros used by the top level of the point splat shader rtl
`ifndef ZBUFFER_POINT_SPLAT_SHADER_ASSERT_SVH
`define ZBUFFER_POINT_SPLAT_SHADER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ZBPS_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ZBPS_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== rtl/core/zbps_pkg.sv =====
// types, constants and lookup functions of the point splat shader
package zbps_pkg;

  // default geometry
  localparam int SCREEN_COLS_DEF = 100;
  localparam int SCREEN_ROWS_DEF = 40;
  localparam int SOURCE_SIZE_DEF = 128;
  localparam int QUEUE_DEPTH_DEF = 4;

  // source coordinate range given by the 7-bit texel position
  localparam int SRC_COORDS = 128;

  // fixed point constants, 14 fraction bits
  localparam int ONE_Q      = 16384;
  localparam int HALF_Q     = 8192;
  localparam int PERSP_GAIN = 13107;
  localparam int SIDE_LIMIT = 803;
  localparam int SLICE_EDGE = 819;
  localparam int NUM_SLICES = 21;
  localparam int SHADE_MAX  = 12;

  // character codes
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_BANG   = 8'h21;
  localparam logic [7:0] CHAR_DIGIT0 = 8'h30;

  // command codes on the input
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SPLAT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // operations passed from front to back
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_READ  = 2'd1,
    OP_SLICE = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROT_COS = 3'd0,
    CFG_ROT_SIN = 3'd1,
    CFG_LIGHT_X = 3'd2,
    CFG_LIGHT_Y = 3'd3,
    CFG_LIGHT_Z = 3'd4
  } cfg_idx_e;

  // configuration register set
  typedef struct packed {
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
    logic signed [17:0] light_x;
    logic signed [17:0] light_y;
    logic signed [17:0] light_z;
  } cfg_t;

  // one queued operation
  typedef struct packed {
    op_e                op;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [10:0] z;
    logic               side;
    logic [4:0]         angle;
    logic [11:0]        cell_addr;
  } slice_t;

  // z of each side slice
  function automatic logic signed [10:0] zslice(input logic [4:0] k);
    logic signed [10:0] z;
    case (k)
      5'd0:    z = -11'sd819;
      5'd1:    z = -11'sd737;
      5'd2:    z = -11'sd655;
      5'd3:    z = -11'sd573;
      5'd4:    z = -11'sd492;
      5'd5:    z = -11'sd410;
      5'd6:    z = -11'sd328;
      5'd7:    z = -11'sd246;
      5'd8:    z = -11'sd164;
      5'd9:    z = -11'sd82;
      5'd10:   z = 11'sd0;
      5'd11:   z = 11'sd82;
      5'd12:   z = 11'sd164;
      5'd13:   z = 11'sd246;
      5'd14:   z = 11'sd328;
      5'd15:   z = 11'sd410;
      5'd16:   z = 11'sd492;
      5'd17:   z = 11'sd573;
      5'd18:   z = 11'sd655;
      5'd19:   z = 11'sd737;
      5'd20:   z = 11'sd819;
      default: z = 11'sd0;
    endcase
    return z;
  endfunction

  // cosine of 32 angle steps, Q1.14
  function automatic logic signed [15:0] cos_lut(input logic [4:0] a);
    logic signed [15:0] v;
    case (a)
      5'd0:    v = 16'sd16384;
      5'd1:    v = 16'sd16069;
      5'd2:    v = 16'sd15137;
      5'd3:    v = 16'sd13623;
      5'd4:    v = 16'sd11585;
      5'd5:    v = 16'sd9102;
      5'd6:    v = 16'sd6270;
      5'd7:    v = 16'sd3196;
      5'd8:    v = 16'sd0;
      5'd9:    v = -16'sd3196;
      5'd10:   v = -16'sd6270;
      5'd11:   v = -16'sd9102;
      5'd12:   v = -16'sd11585;
      5'd13:   v = -16'sd13623;
      5'd14:   v = -16'sd15137;
      5'd15:   v = -16'sd16069;
      5'd16:   v = -16'sd16384;
      5'd17:   v = -16'sd16069;
      5'd18:   v = -16'sd15137;
      5'd19:   v = -16'sd13623;
      5'd20:   v = -16'sd11585;
      5'd21:   v = -16'sd9102;
      5'd22:   v = -16'sd6270;
      5'd23:   v = -16'sd3196;
      5'd24:   v = 16'sd0;
      5'd25:   v = 16'sd3196;
      5'd26:   v = 16'sd6270;
      5'd27:   v = 16'sd9102;
      5'd28:   v = 16'sd11585;
      5'd29:   v = 16'sd13623;
      5'd30:   v = 16'sd15137;
      default: v = 16'sd16069;
    endcase
    return v;
  endfunction

  // shade ramp characters
  function automatic logic [7:0] ramp_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h20;
      4'd1:    c = 8'h2e;
      4'd2:    c = 8'h2c;
      4'd3:    c = 8'h2d;
      4'd4:    c = 8'h7e;
      4'd5:    c = 8'h3a;
      4'd6:    c = 8'h3b;
      4'd7:    c = 8'h3d;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h2a;
      4'd10:   c = 8'h23;
      4'd11:   c = 8'h24;
      4'd12:   c = 8'h40;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/zbps_queue.sv =====
// short fifo of operations between front and back
module zbps_queue #(
  parameter int Depth = zbps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  zbps_pkg::slice_t push_data_i,
  input  logic             pop_i,
  output zbps_pkg::slice_t pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  zbps_pkg::slice_t   store_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = store_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/zbps_front.sv =====
// command decode and slice generation
module zbps_front #(
  parameter int SourceSize = zbps_pkg::SOURCE_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       command_i,
  input  logic [6:0]       src_col_i,
  input  logic [6:0]       src_row_i,
  input  logic [7:0]       glyph_i,
  input  logic [11:0]      cell_index_i,
  input  logic             q_full_i,
  output logic             push_o,
  output zbps_pkg::slice_t push_data_o,
  output logic             busy_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DEC  = 3'b010,
    F_GEN  = 3'b100
  } front_state_e;

  front_state_e       state_q, state_d;
  zbps_pkg::cmd_e     cmd_q;
  logic [7:0]         glyph_q;
  logic [11:0]        cell_q;
  logic signed [17:0] x_q, y_q;
  logic [4:0]         k_q, k_d;
  logic               face_q;
  logic [16:0]        pos_tab [zbps_pkg::SRC_COORDS];
  logic signed [10:0] z_gen;
  logic               last_gen;

  // texel position table, worked out at elaboration
  for (genvar g = 0; g < zbps_pkg::SRC_COORDS; g++) begin : g_pos
    assign pos_tab[g] = 17'((g * zbps_pkg::ONE_Q) / SourceSize);
  end

  // z and end of the slice walk
  always_comb begin
    if (face_q) begin
      z_gen    = (k_q == 5'd0) ? -11'(zbps_pkg::SLICE_EDGE) : 11'(zbps_pkg::SLICE_EDGE);
      last_gen = (k_q == 5'd1);
    end else begin
      z_gen    = zbps_pkg::zslice(k_q);
      last_gen = (k_q == 5'(zbps_pkg::NUM_SLICES - 1));
    end
  end

  // state sequencing and queue push
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    push_o      = 1'b0;
    push_data_o = '0;
    push_data_o.cell_addr = cell_q;
    case (state_q)
      F_IDLE: begin
        if (accept_i) begin
          state_d = F_DEC;
        end
      end
      F_DEC: begin
        k_d = '0;
        case (cmd_q)
          zbps_pkg::CMD_CLEAR: begin
            push_data_o.op = zbps_pkg::OP_CLEAR;
            push_o = !q_full_i;
            if (!q_full_i) state_d = F_IDLE;
          end
          zbps_pkg::CMD_READ: begin
            push_data_o.op = zbps_pkg::OP_READ;
            push_o = !q_full_i;
            if (!q_full_i) state_d = F_IDLE;
          end
          zbps_pkg::CMD_SPLAT: begin
            state_d = (glyph_q == zbps_pkg::CHAR_SPACE) ? F_IDLE : F_GEN;
          end
          default: begin
            state_d = F_IDLE;
          end
        endcase
      end
      F_GEN: begin
        push_data_o.op    = zbps_pkg::OP_SLICE;
        push_data_o.x     = x_q;
        push_data_o.y     = y_q;
        push_data_o.z     = z_gen;
        push_data_o.side  = !face_q && (z_gen > -11'(zbps_pkg::SIDE_LIMIT))
                            && (z_gen < 11'(zbps_pkg::SIDE_LIMIT));
        push_data_o.angle = 5'(glyph_q - zbps_pkg::CHAR_DIGIT0);
        push_o = !q_full_i;
        if (!q_full_i) begin
          k_d = k_q + 1'b1;
          if (last_gen) state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != F_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept_i && state_q == F_IDLE) begin
      cmd_q   <= zbps_pkg::cmd_e'(command_i);
      glyph_q <= glyph_i;
      cell_q  <= cell_index_i;
      face_q  <= (glyph_i == zbps_pkg::CHAR_BANG);
      x_q     <= $signed({1'b0, pos_tab[src_col_i]}) - 18'(zbps_pkg::HALF_Q);
      y_q     <= $signed({1'b0, pos_tab[src_row_i]}) - 18'(zbps_pkg::HALF_Q);
    end
  end

endmodule

// ===== rtl/core/zbps_back.sv =====
// slice projection, depth test, shading and frame memories
module zbps_back #(
  parameter int ScreenCols = zbps_pkg::SCREEN_COLS_DEF,
  parameter int ScreenRows = zbps_pkg::SCREEN_ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  zbps_pkg::cfg_t   cfg_i,
  input  logic             q_empty_i,
  input  zbps_pkg::slice_t q_data_i,
  output logic             q_pop_o,
  output logic             busy_o,
  output logic             result_valid_o,
  output logic [7:0]       cell_char_o
);

  localparam int CellCount = ScreenCols * ScreenRows;
  localparam int AddrW     = $clog2(CellCount);
  localparam logic signed [9:0]  GainX  = 10'(2 * ScreenRows);
  localparam logic signed [9:0]  GainY  = 10'(ScreenRows);
  localparam logic signed [9:0]  ColsS  = 10'(ScreenCols);
  localparam logic signed [27:0] TxOff  = 28'((ScreenCols / 2 - ScreenRows) / 2);
  localparam logic signed [14:0] PGain  = 15'(zbps_pkg::PERSP_GAIN);

  typedef enum logic [17:0] {
    B_CLR    = 18'h00001,
    B_IDLE   = 18'h00002,
    B_RD     = 18'h00004,
    B_RDOUT  = 18'h00008,
    B_M1     = 18'h00010,
    B_M2     = 18'h00020,
    B_M3     = 18'h00040,
    B_M4     = 18'h00080,
    B_M5     = 18'h00100,
    B_M6     = 18'h00200,
    B_M7     = 18'h00400,
    B_M8     = 18'h00800,
    B_DRD    = 18'h01000,
    B_DCMP   = 18'h02000,
    B_SQRT   = 18'h04000,
    B_SHINIT = 18'h08000,
    B_SHADE  = 18'h10000,
    B_WR     = 18'h20000
  } back_state_e;

  back_state_e        state_q, state_d;
  zbps_pkg::slice_t   item_q;
  logic [AddrW-1:0]   clr_cnt_q, clr_cnt_d;

  // pipeline registers
  logic signed [33:0] xc_q, xs_q;
  logic signed [26:0] zs_q, zc_q;
  logic signed [31:0] nc_q, ns_q;
  logic signed [15:0] ny_q;
  logic signed [20:0] rx_q, rz_q;
  logic signed [17:0] rnx_q, rnz_q;
  logic signed [36:0] pp_q;
  logic signed [21:0] vx_q, vz_q;
  logic signed [18:0] vy_q;
  logic signed [22:0] p_q;
  logic signed [39:0] dx_q, dz_q;
  logic signed [34:0] dy_q;
  logic signed [43:0] sx_q, sz_q;
  logic signed [37:0] sy_q;
  logic signed [44:0] ax_q;
  logic signed [41:0] ay_q;
  logic signed [41:0] dot_q;
  logic [45:0]        mag_q;
  logic signed [54:0] axm_q;
  logic signed [51:0] aym_q;
  logic signed [45:0] dot12_q;
  logic signed [27:0] tx_q;
  logic signed [23:0] qy_q;
  logic signed [35:0] idx_q;
  logic               inrange_q;
  logic [15:0]        tz_q;
  logic               rd_ok_q;

  // root and shade iteration registers
  logic [45:0]        sq_n_q, sq_r_q, sq_b_q;
  logic [4:0]         sq_cnt_q;
  logic [47:0]        thr_q, step_q;
  logic [3:0]         sh_q;

  // frame memories
  logic [15:0]        depth_mem_q [CellCount];
  logic [7:0]         shade_mem_q [CellCount];
  logic [15:0]        depth_rdata_q;
  logic [7:0]         shade_rdata_q;
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  logic [15:0]        mem_wdepth;
  logic [7:0]         mem_wshade;

  // stage combinational values
  logic signed [15:0] n_c;
  logic signed [34:0] rxs_c, rzs_c;
  logic signed [31:0] ncr_c, nsr_c;
  logic signed [36:0] ppr_c;
  logic signed [21:0] rz1_c;
  logic signed [43:0] axp_c;
  logic signed [40:0] ayp_c;
  logic signed [54:0] axr_c;
  logic signed [51:0] ayr_c;
  logic signed [26:0] qx_c;
  logic signed [33:0] ymul_c;
  logic signed [35:0] idx_c;
  logic signed [21:0] tzs_c;
  logic [46:0]        sq_sum_c;
  logic               dot_pos_c;
  logic               cell_ok_c;

  assign busy_o         = (state_q != B_IDLE);
  assign q_pop_o        = (state_q == B_IDLE) && !q_empty_i;
  assign result_valid_o = (state_q == B_RDOUT);
  assign cell_char_o    = rd_ok_q ? shade_rdata_q : 8'h00;

  // normal source value: table for sides, sign of z otherwise
  assign n_c = item_q.side ? zbps_pkg::cos_lut(item_q.angle)
             : ((item_q.z > 11'sd0) ? 16'(zbps_pkg::ONE_Q) : -16'(zbps_pkg::ONE_Q));

  // rotation sums, Q.28 rounded to nearest Q.14 with ties upward
  assign rxs_c = 35'(xc_q) - 35'(zs_q) + 35'(zbps_pkg::HALF_Q);
  assign rzs_c = 35'(xs_q) + 35'(zc_q) + 35'(zbps_pkg::HALF_Q);
  assign ncr_c = nc_q + 32'(zbps_pkg::HALF_Q);
  assign nsr_c = ns_q + 32'(zbps_pkg::HALF_Q);
  assign rz1_c = 22'(rz_q) + 22'(zbps_pkg::ONE_Q);
  assign ppr_c = pp_q + 37'(zbps_pkg::HALF_Q);

  // perspective products
  assign axp_c = rx_q * p_q;
  assign ayp_c = item_q.y * p_q;

  // quotient by 2^28 truncated toward zero
  assign axr_c = axm_q[54] ? axm_q + 55'((1 << 28) - 1) : axm_q;
  assign ayr_c = aym_q[51] ? aym_q + 52'((1 << 28) - 1) : aym_q;
  assign qx_c  = axr_c[54:28];

  // cell index and depth
  assign ymul_c = qy_q * ColsS;
  assign idx_c  = 36'(tx_q) + 36'(ymul_c);
  assign tzs_c  = 22'(rz_q) + 22'sd32768;

  assign sq_sum_c  = {1'b0, sq_r_q} + {1'b0, sq_b_q};
  assign dot_pos_c = !dot12_q[45] && (dot12_q != '0);
  assign cell_ok_c = ({20'd0, item_q.cell_addr} < 32'(CellCount));

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      B_CLR: begin
        if (clr_cnt_q == AddrW'(CellCount - 1)) begin
          clr_cnt_d = '0;
          state_d   = B_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          case (q_data_i.op)
            zbps_pkg::OP_CLEAR: state_d = B_CLR;
            zbps_pkg::OP_READ:  state_d = B_RD;
            zbps_pkg::OP_SLICE: state_d = B_M1;
            default:            state_d = B_IDLE;
          endcase
        end
      end
      B_RD:     state_d = B_RDOUT;
      B_RDOUT:  state_d = B_IDLE;
      B_M1:     state_d = B_M2;
      B_M2:     state_d = B_M3;
      B_M3:     state_d = B_M4;
      B_M4:     state_d = B_M5;
      B_M5:     state_d = B_M6;
      B_M6:     state_d = B_M7;
      B_M7:     state_d = B_M8;
      B_M8:     state_d = B_DRD;
      B_DRD:    state_d = inrange_q ? B_DCMP : B_IDLE;
      B_DCMP:   state_d = (depth_rdata_q < tz_q) ? B_SQRT : B_IDLE;
      B_SQRT:   state_d = (sq_cnt_q == 5'd22) ? B_SHINIT : B_SQRT;
      B_SHINIT: state_d = (dot_pos_c && (sq_r_q != '0)) ? B_SHADE : B_WR;
      B_SHADE: begin
        if (!(({2'b00, dot12_q} >= thr_q) && (sh_q != 4'(zbps_pkg::SHADE_MAX)))) begin
          state_d = B_WR;
        end
      end
      B_WR:     state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_CLR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // datapath registers, loaded by stage
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        item_q <= q_data_i;
      end
      B_RD: begin
        rd_ok_q <= cell_ok_c;
      end
      B_M1: begin
        xc_q <= item_q.x * cfg_i.rot_cos;
        xs_q <= item_q.x * cfg_i.rot_sin;
        zs_q <= item_q.z * cfg_i.rot_sin;
        zc_q <= item_q.z * cfg_i.rot_cos;
        nc_q <= n_c * cfg_i.rot_cos;
        ns_q <= n_c * cfg_i.rot_sin;
        ny_q <= item_q.side ? zbps_pkg::cos_lut(item_q.angle - 5'd8) : 16'sd0;
      end
      B_M2: begin
        rx_q  <= rxs_c[34:14];
        rz_q  <= rzs_c[34:14];
        rnx_q <= item_q.side ? ncr_c[31:14] : nsr_c[31:14];
        rnz_q <= item_q.side ? nsr_c[31:14] : ncr_c[31:14];
      end
      B_M3: begin
        pp_q <= rz1_c * PGain;
        vx_q <= 22'(cfg_i.light_x) - 22'(rx_q);
        vy_q <= 19'(cfg_i.light_y) - 19'(item_q.y);
        vz_q <= 22'(cfg_i.light_z) - 22'(rz_q);
      end
      B_M4: begin
        p_q  <= ppr_c[36:14];
        dx_q <= vx_q * rnx_q;
        dy_q <= vy_q * ny_q;
        dz_q <= vz_q * rnz_q;
        sx_q <= vx_q * vx_q;
        sy_q <= vy_q * vy_q;
        sz_q <= vz_q * vz_q;
      end
      B_M5: begin
        ax_q  <= 45'(axp_c) + 45'sd134217728;
        ay_q  <= 42'(ayp_c) + 42'sd134217728;
        dot_q <= 42'(dx_q) + 42'(dy_q) + 42'(dz_q);
        mag_q <= 46'(sx_q) + 46'(sy_q) + 46'(sz_q);
      end
      B_M6: begin
        axm_q   <= ax_q * GainX;
        aym_q   <= ay_q * GainY;
        dot12_q <= (46'(dot_q) <<< 3) + (46'(dot_q) <<< 2);
      end
      B_M7: begin
        tx_q <= 28'(qx_c) + TxOff;
        qy_q <= ayr_c[51:28];
      end
      B_M8: begin
        idx_q     <= idx_c;
        inrange_q <= !idx_c[35] && (idx_c < 36'(CellCount));
        if (tzs_c < 22'sd0) begin
          tz_q <= 16'h0000;
        end else if (tzs_c > 22'sd65535) begin
          tz_q <= 16'hffff;
        end else begin
          tz_q <= tzs_c[15:0];
        end
      end
      B_DCMP: begin
        sq_n_q   <= mag_q;
        sq_r_q   <= '0;
        sq_b_q   <= 46'(1) << 44;
        sq_cnt_q <= '0;
      end
      B_SQRT: begin
        // one result bit per cycle
        if ({1'b0, sq_n_q} >= sq_sum_c) begin
          sq_n_q <= sq_n_q - sq_sum_c[45:0];
          sq_r_q <= (sq_r_q >> 1) + sq_b_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_b_q   <= sq_b_q >> 2;
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end
      B_SHINIT: begin
        sh_q   <= '0;
        thr_q  <= {12'd0, sq_r_q[22:0], 13'd0};
        step_q <= {11'd0, sq_r_q[22:0], 14'd0};
      end
      B_SHADE: begin
        // count ramp steps whose threshold the dot product reaches
        if (({2'b00, dot12_q} >= thr_q) && (sh_q != 4'(zbps_pkg::SHADE_MAX))) begin
          sh_q  <= sh_q + 1'b1;
          thr_q <= thr_q + step_q;
        end
      end
      default: begin
      end
    endcase
  end

  // memory write port select
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt_q;
    mem_wdepth = 16'h0000;
    mem_wshade = zbps_pkg::CHAR_SPACE;
    if (state_q == B_CLR) begin
      mem_we = 1'b1;
    end else if (state_q == B_WR) begin
      mem_we     = 1'b1;
      mem_waddr  = idx_q[AddrW-1:0];
      mem_wdepth = tz_q;
      mem_wshade = zbps_pkg::ramp_char(sh_q);
    end
  end

  // depth and shade memories, registered reads
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      depth_mem_q[mem_waddr] <= mem_wdepth;
      shade_mem_q[mem_waddr] <= mem_wshade;
    end
    depth_rdata_q <= depth_mem_q[idx_q[AddrW-1:0]];
    shade_rdata_q <= shade_mem_q[AddrW'(item_q.cell_addr)];
  end

endmodule

// ===== rtl/core/zbuffer_point_splat_shader.sv =====
// top level of the point splat shader: config registers, front, queue and back
//
// Commands enter on start/busy: a beat is taken at a clock edge with start
// high and busy low. Command 0 clears the frame, 1 splats one glyph texel,
// 2 reads one cell, 3 is ignored. Only a read gives a result: cell_char_o
// is shown for one cycle with result_valid_o high and cannot be held off.
// A read result comes from a shade memory read that the back starts once
// the read leaves the queue. A splat walks 2 slices for a face texel or
// 21 for a side texel; each slice goes from the queue through the multiply
// stages and the depth lookup, then the depth compare, and a slice that
// wins the depth test goes on through the bit-serial square root and the
// shade step count before it is written. A space texel or an unused command
// ends in decode with nothing queued. A clear sweeps all cols * rows cells
// (4000 at the default size) of both frame memories one cell per cycle.
// Busy stays high until the whole item is done. After reset the same sweep
// runs before the first command is taken. Configuration writes on cfg_we_i
// land at once. The user must make them while idle; the block does not check.
`include "zbuffer_point_splat_shader_assert.svh"

module zbuffer_point_splat_shader #(
  parameter int ScreenCols = zbps_pkg::SCREEN_COLS_DEF,
  parameter int ScreenRows = zbps_pkg::SCREEN_ROWS_DEF,
  parameter int SourceSize = zbps_pkg::SOURCE_SIZE_DEF,
  parameter int QueueDepth = zbps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [6:0]  src_col_i,
  input  logic [6:0]  src_row_i,
  input  logic [7:0]  glyph_i,
  input  logic [11:0] cell_index_i,
  output logic        result_valid_o,
  output logic [7:0]  cell_char_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [17:0] cfg_wdata_i
);

  zbps_pkg::cfg_t   cfg_q, cfg_d;
  zbps_pkg::slice_t q_push_data, q_pop_data;
  logic             accept;
  logic             q_push, q_pop, q_full, q_empty;
  logic             front_busy, back_busy;

  assign accept = start && !busy;
  assign busy   = front_busy || !q_empty || back_busy;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        zbps_pkg::CFG_ROT_COS: cfg_d.rot_cos = cfg_wdata_i[15:0];
        zbps_pkg::CFG_ROT_SIN: cfg_d.rot_sin = cfg_wdata_i[15:0];
        zbps_pkg::CFG_LIGHT_X: cfg_d.light_x = cfg_wdata_i;
        zbps_pkg::CFG_LIGHT_Y: cfg_d.light_y = cfg_wdata_i;
        zbps_pkg::CFG_LIGHT_Z: cfg_d.light_z = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_cos <= 16'sd16384;
      cfg_q.rot_sin <= 16'sd0;
      cfg_q.light_x <= 18'sd0;
      cfg_q.light_y <= 18'sd0;
      cfg_q.light_z <= 18'sd49152;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // command decode
  zbps_front #(
    .SourceSize (SourceSize)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (command_i),
    .src_col_i    (src_col_i),
    .src_row_i    (src_row_i),
    .glyph_i      (glyph_i),
    .cell_index_i (cell_index_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_data_o  (q_push_data),
    .busy_o       (front_busy)
  );

  // operation queue
  zbps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // slice execution and frame memories
  zbps_back #(
    .ScreenCols (ScreenCols),
    .ScreenRows (ScreenRows)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .q_data_i       (q_pop_data),
    .q_pop_o        (q_pop),
    .busy_o         (back_busy),
    .result_valid_o (result_valid_o),
    .cell_char_o    (cell_char_o)
  );

  // checks
  `ZBPS_ASSERT_NXT(a_accept_then_busy, start && !busy, busy, "busy low after accepted beat")
  `ZBPS_ASSERT_IMP(a_result_while_busy, result_valid_o, busy, "result outside a busy item")
  `ZBPS_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full, "push into full queue")

endmodule

// ===== dv/tb_zbuffer_point_splat_shader.sv =====
// testbench of the point splat shader: directed and random commands checked against a frame predictor
`timescale 1ns / 1ps

// frame predictor and store of expected read characters
class splat_frame_board;
  logic [15:0] depth_mem [4000];
  logic [7:0]  char_mem [4000];
  longint      cos_q, sin_q, lx, ly, lz;
  logic [7:0]  expected_chars [$];
  int          fail_count;
  longint      angle_cos [32] = '{
    16384, 16069, 15137, 13623, 11585, 9102, 6270, 3196,
    0, -3196, -6270, -9102, -11585, -13623, -15137, -16069,
    -16384, -16069, -15137, -13623, -11585, -9102, -6270, -3196,
    0, 3196, 6270, 9102, 11585, 13623, 15137, 16069};
  string       shade_ramp = " .,-~:;=!*#$@";

  function new();
    wipe();
    cos_q = 16384;
    sin_q = 0;
    lx = 0;
    ly = 0;
    lz = 49152;
    fail_count = 0;
  endfunction

  function void wipe();
    foreach (depth_mem[i]) begin
      depth_mem[i] = '0;
      char_mem[i] = zbps_pkg::CHAR_SPACE;
    end
  endfunction

  function void set_reg(zbps_pkg::cfg_idx_e idx, logic [17:0] val);
    case (idx)
      zbps_pkg::CFG_ROT_COS: cos_q = longint'($signed(val[15:0]));
      zbps_pkg::CFG_ROT_SIN: sin_q = longint'($signed(val[15:0]));
      zbps_pkg::CFG_LIGHT_X: lx = longint'($signed(val));
      zbps_pkg::CFG_LIGHT_Y: ly = longint'($signed(val));
      zbps_pkg::CFG_LIGHT_Z: lz = longint'($signed(val));
      default: ;
    endcase
  endfunction

  // divide by one in q.14, nearest with ties upward
  function longint q_round(longint v);
    longint t;
    t = v + 8192;
    if (t >= 0) return t >>> 14;
    return -((-t + 16383) >>> 14);
  endfunction

  function longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // project one z slice and apply depth test and shading
  function void splat_slice(longint x, longint y, longint z, logic [7:0] glyph, bit face);
    longint rx, rz, p, tx, ty, idx, tz, nx, ny, nz, rnx, rnz, vx, vy, vz, dot, d, sh, den;
    logic [4:0] a;
    rx = q_round(x * cos_q - z * sin_q);
    rz = q_round(x * sin_q + z * cos_q);
    p = q_round(64'd13107 * (16384 + rz));
    tx = ((rx * p + (64'sd1 <<< 27)) * 80) / (64'sd1 <<< 28) + 5;
    ty = ((y * p + (64'sd1 <<< 27)) * 40) / (64'sd1 <<< 28);
    idx = tx + ty * 100;
    if (idx < 0 || idx >= 4000) return;
    tz = rz + 32768;
    if (tz < 0) tz = 0;
    if (tz > 65535) tz = 65535;
    if (!(longint'(depth_mem[idx]) < tz)) return;
    depth_mem[idx] = tz[15:0];
    nx = 0;
    ny = 0;
    nz = 0;
    if (!face && z > -803 && z < 803) begin
      a = glyph[4:0] - 5'd16;
      nx = angle_cos[a];
      ny = angle_cos[5'(a - 5'd8)];
    end else begin
      nz = (z > 0) ? 16384 : ((z < 0) ? -16384 : 0);
    end
    rnx = q_round(nx * cos_q + nz * sin_q);
    rnz = q_round(nx * sin_q + nz * cos_q);
    vx = lx - rx;
    vy = ly - y;
    vz = lz - rz;
    dot = vx * rnx + vy * ny + vz * rnz;
    d = int_sqrt(longint'(vx * vx + vy * vy + vz * vz));
    sh = 0;
    if (dot > 0 && d > 0) begin
      den = d * 16384;
      sh = (12 * dot + den / 2) / den;
      if (sh > 12) sh = 12;
    end
    char_mem[idx] = shade_ramp[sh];
  endfunction

  // note one accepted command beat
  function void note_beat(zbps_pkg::cmd_e cmd, logic [6:0] col, logic [6:0] row,
                          logic [7:0] glyph, logic [11:0] cell_idx);
    longint x, y, n, z;
    case (cmd)
      zbps_pkg::CMD_CLEAR: wipe();
      zbps_pkg::CMD_SPLAT: begin
        if (glyph != zbps_pkg::CHAR_SPACE) begin
          x = longint'(col) * 128 - 8192;
          y = longint'(row) * 128 - 8192;
          if (glyph == zbps_pkg::CHAR_BANG) begin
            splat_slice(x, y, -819, glyph, 1'b1);
            splat_slice(x, y, 819, glyph, 1'b1);
          end else begin
            for (int k = 0; k <= 20; k++) begin
              n = longint'(k - 10) * 8192;
              z = (n >= 0) ? (n + 50) / 100 : -((-n + 50) / 100);
              splat_slice(x, y, z, glyph, 1'b0);
            end
          end
        end
      end
      zbps_pkg::CMD_READ:
        expected_chars.push_back((cell_idx < 4000) ? char_mem[cell_idx] : 8'h00);
      default: ;
    endcase
  endfunction

  function void check_char(logic [7:0] got);
    logic [7:0] want;
    if (expected_chars.size() == 0) begin
      $error("cell_char result with no read pending: actual %h", got);
      fail_count++;
      return;
    end
    want = expected_chars.pop_front();
    if (got !== want) begin
      $error("cell_char mismatch: expected %h actual %h", want, got);
      fail_count++;
    end
  endfunction
endclass

module tb_zbuffer_point_splat_shader;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [6:0]  src_col_i;
  logic [6:0]  src_row_i;
  logic [7:0]  glyph_i;
  logic [11:0] cell_index_i;
  logic        result_valid_o;
  logic [7:0]  cell_char_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [17:0] cfg_wdata_i;

  splat_frame_board frame_board;
  int               stall_cycles;

  zbuffer_point_splat_shader u_dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .src_col_i, .src_row_i, .glyph_i,
    .cell_index_i, .result_valid_o, .cell_char_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result check, sampled at the edge that ends the result cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) frame_board.check_char(cell_char_o);
  end

  // watchdog on cycles without any accepted beat or read result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 40000) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // issue one command beat after a random gap, hold until taken
  task automatic send_cmd(zbps_pkg::cmd_e cmd, logic [6:0] col, logic [6:0] row,
                          logic [7:0] glyph, logic [11:0] cell_idx);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    command_i    <= cmd;
    src_col_i    <= col;
    src_row_i    <= row;
    glyph_i      <= glyph;
    cell_index_i <= cell_idx;
    do @(posedge clk_i); while (busy);
    frame_board.note_beat(cmd, col, row, glyph, cell_idx);
  endtask

  // stop sending and wait for every read to return and the block to settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (frame_board.expected_chars.size() != 0 || busy) @(posedge clk_i);
  endtask

  // one register write beat; the caller drops the write enable afterward
  task automatic write_reg(zbps_pkg::cfg_idx_e idx, logic [17:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    frame_board.set_reg(idx, val);
  endtask

  task automatic set_view(logic [15:0] c, logic [15:0] s, logic [17:0] x,
                          logic [17:0] y, logic [17:0] z);
    drain();
    write_reg(zbps_pkg::CFG_ROT_COS, {2'b00, c});
    write_reg(zbps_pkg::CFG_ROT_SIN, {2'b00, s});
    write_reg(zbps_pkg::CFG_LIGHT_X, x);
    write_reg(zbps_pkg::CFG_LIGHT_Y, y);
    write_reg(zbps_pkg::CFG_LIGHT_Z, z);
    cfg_we_i <= 1'b0;
  endtask

  // read biased toward cells that splats reach
  task automatic read_cell();
    logic [11:0] cell_idx;
    if ($urandom_range(0, 4) == 0) cell_idx = 12'($urandom_range(0, 4095));
    else cell_idx = 12'($urandom_range(0, 20) * 100 + $urandom_range(0, 45));
    send_cmd(zbps_pkg::CMD_READ, 7'($urandom), 7'($urandom), 8'($urandom), cell_idx);
  endtask

  task automatic random_beats(int count);
    int pick;
    logic [7:0] glyph;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0: glyph = zbps_pkg::CHAR_BANG;
          1: glyph = 8'($urandom);
          2: glyph = zbps_pkg::CHAR_SPACE;
          default: glyph = zbps_pkg::CHAR_DIGIT0 + 8'($urandom_range(0, 31));
        endcase
        send_cmd(zbps_pkg::CMD_SPLAT, 7'($urandom), 7'($urandom), glyph, 12'($urandom));
      end else if (pick < 97) begin
        read_cell();
      end else if (pick < 98) begin
        send_cmd(zbps_pkg::CMD_CLEAR, 7'($urandom), 7'($urandom), 8'($urandom),
                 12'($urandom));
      end else begin
        send_cmd(zbps_pkg::CMD_NONE, 7'($urandom), 7'($urandom), 8'($urandom),
                 12'($urandom));
      end
    end
  endtask

  // light anywhere in range, mostly within plus or minus 49152
  function automatic logic [17:0] rand_light();
    if ($urandom_range(0, 3) == 0) return 18'($urandom);
    return 18'($urandom_range(0, 98304) - 49152);
  endfunction

  initial begin
    int a;
    frame_board  = new();
    stall_cycles = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    command_i    = zbps_pkg::CMD_CLEAR;
    src_col_i    = '0;
    src_row_i    = '0;
    glyph_i      = '0;
    cell_index_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = zbps_pkg::CFG_ROT_COS;
    cfg_wdata_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset frame, range edges, each glyph kind, equal depth, unused command
    send_cmd(zbps_pkg::CMD_READ, 7'd0, 7'd0, 8'd0, 12'd0);
    send_cmd(zbps_pkg::CMD_READ, 7'h7f, 7'h7f, 8'hff, 12'd3999);
    send_cmd(zbps_pkg::CMD_READ, 7'd0, 7'd0, 8'd0, 12'd4000);
    send_cmd(zbps_pkg::CMD_READ, 7'd0, 7'd0, 8'd0, 12'hfff);
    send_cmd(zbps_pkg::CMD_NONE, 7'h7f, 7'h7f, 8'hff, 12'hfff);
    send_cmd(zbps_pkg::CMD_SPLAT, 7'd64, 7'd64, zbps_pkg::CHAR_SPACE, 12'd0);
    send_cmd(zbps_pkg::CMD_SPLAT, 7'd64, 7'd64, zbps_pkg::CHAR_BANG, 12'd0);
    send_cmd(zbps_pkg::CMD_SPLAT, 7'd64, 7'd64, zbps_pkg::CHAR_BANG, 12'd0);
    send_cmd(zbps_pkg::CMD_SPLAT, 7'd0, 7'd0, zbps_pkg::CHAR_DIGIT0, 12'd0);
    send_cmd(zbps_pkg::CMD_SPLAT, 7'h7f, 7'h7f, zbps_pkg::CHAR_DIGIT0 + 8'd8, 12'd0);
    send_cmd(zbps_pkg::CMD_SPLAT, 7'd100, 7'd70, 8'hff, 12'd0);
    send_cmd(zbps_pkg::CMD_SPLAT, 7'd30, 7'd90, 8'h00, 12'd0);
    send_cmd(zbps_pkg::CMD_READ, 7'd0, 7'd0, 8'd0, 12'd805);
    send_cmd(zbps_pkg::CMD_READ, 7'd0, 7'd0, 8'd0, 12'd1637);
    send_cmd(zbps_pkg::CMD_READ, 7'd0, 7'd0, 8'd0, 12'd1005);
    send_cmd(zbps_pkg::CMD_CLEAR, 7'd0, 7'd0, 8'd0, 12'd0);
    send_cmd(zbps_pkg::CMD_READ, 7'd0, 7'd0, 8'd0, 12'd805);

    // light sitting on the texel center
    set_view(16'sd16384, 16'sd0, 18'd0, 18'd0, 18'd0);
    send_cmd(zbps_pkg::CMD_SPLAT, 7'd64, 7'd64, zbps_pkg::CHAR_DIGIT0, 12'd0);
    send_cmd(zbps_pkg::CMD_READ, 7'd0, 7'd0, 8'd0, 12'd805);

    // random phases over rotation and light extremes
    random_beats(138);
    set_view(-16'sd16384, 16'sd0, 18'h1ffff, 18'h20000, 18'h1ffff);
    random_beats(138);
    set_view(16'sd0, 16'sd16384, 18'h20000, 18'h1ffff, 18'h20000);
    random_beats(138);
    set_view(16'sd0, -16'sd16384, 18'd0, 18'd0, 18'd49152);
    random_beats(138);
    for (int ph = 0; ph < 2; ph++) begin
      a = $urandom_range(0, 31);
      set_view(16'(frame_board.angle_cos[a]), 16'(frame_board.angle_cos[(a + 24) % 32]),
               rand_light(), rand_light(), rand_light());
      random_beats(138);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (frame_board.expected_chars.size() != 0) begin
      $error("%0d read results never arrived", frame_board.expected_chars.size());
      frame_board.fail_count++;
    end
    if (frame_board.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/zbps_pkg.sv
rtl/core/zbps_queue.sv
rtl/core/zbps_front.sv
rtl/core/zbps_back.sv
rtl/core/zbuffer_point_splat_shader.sv
dv/tb_zbuffer_point_splat_shader.sv
